>>> design/via_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// via_pkg
// Types and codes shared by the interface adapter core and its top level.
// ----------------------------------------------------------------------------
package via_pkg;

	// item commands
	localparam logic [3:0] CMD_READ      = 4'd0;
	localparam logic [3:0] CMD_WRITE     = 4'd1;
	localparam logic [3:0] CMD_TICK      = 4'd2;
	localparam logic [3:0] CMD_SHIFT_IN  = 4'd3;
	localparam logic [3:0] CMD_SHIFT_OUT = 4'd4;
	localparam logic [3:0] CMD_CA1       = 4'd5;
	localparam logic [3:0] CMD_CA2       = 4'd6;
	localparam logic [3:0] CMD_CB1       = 4'd7;
	localparam logic [3:0] CMD_CB2       = 4'd8;

	// register map
	localparam logic [3:0] REG_ORB    = 4'h0;
	localparam logic [3:0] REG_ORA    = 4'h1;
	localparam logic [3:0] REG_DDRB   = 4'h2;
	localparam logic [3:0] REG_DDRA   = 4'h3;
	localparam logic [3:0] REG_T1CL   = 4'h4;
	localparam logic [3:0] REG_T1CH   = 4'h5;
	localparam logic [3:0] REG_T1LL   = 4'h6;
	localparam logic [3:0] REG_T1LH   = 4'h7;
	localparam logic [3:0] REG_T2CL   = 4'h8;
	localparam logic [3:0] REG_T2CH   = 4'h9;
	localparam logic [3:0] REG_SR     = 4'hA;
	localparam logic [3:0] REG_ACR    = 4'hB;
	localparam logic [3:0] REG_PCR    = 4'hC;
	localparam logic [3:0] REG_IFR    = 4'hD;
	localparam logic [3:0] REG_IER    = 4'hE;
	localparam logic [3:0] REG_ORA_NH = 4'hF;

	// interrupt flag bit positions
	localparam int FLAG_CA2 = 0;
	localparam int FLAG_CA1 = 1;
	localparam int FLAG_SR  = 2;
	localparam int FLAG_CB2 = 3;
	localparam int FLAG_CB1 = 4;
	localparam int FLAG_T2  = 5;
	localparam int FLAG_T1  = 6;
	localparam int NUM_FLAGS = 7;

	// ACR shift modes, bits 4..2
	localparam logic [2:0] SR_MODE_OFF      = 3'd0;
	localparam logic [2:0] SR_MODE_IN_EXT   = 3'd3;
	localparam logic [2:0] SR_MODE_OUT_PHI2 = 3'd6;
	localparam logic [2:0] SR_MODE_OUT_EXT  = 3'd7;

	// config register indexes
	localparam logic [7:0] CFG_PA_MASK  = 8'd0;
	localparam logic [7:0] CFG_PB_MASK  = 8'd1;
	localparam logic [7:0] CFG_PA_FLOAT = 8'd2;
	localparam logic [7:0] CFG_PB_FLOAT = 8'd3;

	typedef struct packed {
		logic [3:0] command;
		logic [3:0] reg_addr;
		logic [7:0] write_data;
		logic [7:0] shift_byte;
		logic [7:0] port_a_pins;
		logic [7:0] port_b_pins;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] port_a_out;
		logic [7:0] port_b_out;
		logic       cb2_level;
		logic       irq;
		logic       shift_ok;
	} out_item_t;

	typedef struct packed {
		logic [7:0] port_a_input_mask;
		logic [7:0] port_b_input_mask;
		logic [7:0] port_a_float_value;
		logic [7:0] port_b_float_value;
	} cfg_t;

endpackage
`default_nettype wire

>>> design/via_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// via_core
// Adapter register file, timers and interrupt logic. Applies one item per
// enabled cycle; the pin levels, CB2 level and IRQ in the result come from the updated state.
// ----------------------------------------------------------------------------
module via_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  via_pkg::in_item_t   item,
	input  via_pkg::cfg_t       cfg,
	output via_pkg::out_item_t  result
);
	import via_pkg::*;

	logic [7:0]           ora_q, orb_q, ddra_q, ddrb_q;
	logic [15:0]          t1_latch_q, t1_count_q, t2_count_q;
	logic [7:0]           t2_latch_low_q, sr_q, acr_q, pcr_q;
	logic [NUM_FLAGS-1:0] ifr_q, ier_q;
	logic                 t1_armed_q, t2_armed_q, pb7_tog_q, cb2_q;

	logic [7:0]           ora_n, orb_n, ddra_n, ddrb_n;
	logic [15:0]          t1_latch_n, t1_count_n, t2_count_n;
	logic [7:0]           t2_latch_low_n, sr_n, acr_n, pcr_n;
	logic [NUM_FLAGS-1:0] ifr_n, ier_n;
	logic                 t1_armed_n, t2_armed_n, pb7_tog_n, cb2_n;

	logic [7:0] rd;
	logic       ok;
	logic       wr;
	logic [7:0] d;
	logic [2:0] sr_mode;
	logic [7:0] drv_a, drv_b;

	assign wr      = (item.command == CMD_WRITE);
	assign d       = item.write_data;
	assign sr_mode = acr_q[4:2];

	always_comb begin
		ora_n          = ora_q;
		orb_n          = orb_q;
		ddra_n         = ddra_q;
		ddrb_n         = ddrb_q;
		t1_latch_n     = t1_latch_q;
		t1_count_n     = t1_count_q;
		t2_count_n     = t2_count_q;
		t2_latch_low_n = t2_latch_low_q;
		sr_n           = sr_q;
		acr_n          = acr_q;
		pcr_n          = pcr_q;
		ifr_n          = ifr_q;
		ier_n          = ier_q;
		t1_armed_n     = t1_armed_q;
		t2_armed_n     = t2_armed_q;
		pb7_tog_n      = pb7_tog_q;
		cb2_n          = cb2_q;
		rd             = 8'h00;
		ok             = 1'b0;

		case (item.command)
			CMD_READ, CMD_WRITE: begin
				case (item.reg_addr)
					REG_ORB: begin
						if (pcr_q[7:5] == 3'b000)
							ifr_n[FLAG_CB2] = 1'b0;
						ifr_n[FLAG_CB1] = 1'b0;
						if (wr) begin
							orb_n     = d;
							pb7_tog_n = 1'b0;
						end else begin
							rd = (orb_q & ddrb_q)
								| (~ddrb_q & ~cfg.port_b_input_mask & cfg.port_b_float_value)
								| (~ddrb_q & cfg.port_b_input_mask & item.port_b_pins);
						end
					end
					REG_ORA, REG_ORA_NH: begin
						if (pcr_q[3:1] == 3'b000)
							ifr_n[FLAG_CA2] = 1'b0;
						ifr_n[FLAG_CA1] = 1'b0;
						if (wr) begin
							ora_n = d;
						end else begin
							rd = (ora_q & ddra_q)
								| (~ddra_q & ~cfg.port_a_input_mask & cfg.port_a_float_value)
								| (~ddra_q & cfg.port_a_input_mask & item.port_a_pins);
						end
					end
					REG_DDRB: begin
						if (wr) begin
							ddrb_n    = d;
							pb7_tog_n = 1'b0;
						end else begin
							rd = ddrb_q;
						end
					end
					REG_DDRA: begin
						if (wr) ddra_n = d;
						else rd = ddra_q;
					end
					REG_T1CL: begin
						if (wr) begin
							t1_latch_n = {t1_latch_q[15:8], d};
						end else begin
							ifr_n[FLAG_T1] = 1'b0;
							rd = t1_count_q[7:0];
						end
					end
					REG_T1CH: begin
						if (wr) begin
							t1_latch_n     = {d, t1_latch_q[7:0]};
							t1_count_n     = {d, t1_latch_q[7:0]};
							ifr_n[FLAG_T1] = 1'b0;
							if (!acr_q[6])
								t1_armed_n = 1'b1;
						end else begin
							rd = t1_count_q[15:8];
						end
					end
					REG_T1LL: begin
						if (wr) t1_latch_n = {t1_latch_q[15:8], d};
						else rd = t1_latch_q[7:0];
					end
					REG_T1LH: begin
						if (wr) begin
							t1_latch_n     = {d, t1_latch_q[7:0]};
							ifr_n[FLAG_T1] = 1'b0;
						end else begin
							rd = t1_latch_q[15:8];
						end
					end
					REG_T2CL: begin
						if (wr) begin
							t2_latch_low_n = d;
						end else begin
							ifr_n[FLAG_T2] = 1'b0;
							rd = t2_count_q[7:0];
						end
					end
					REG_T2CH: begin
						if (wr) begin
							t2_count_n     = {d, t2_latch_low_q};
							ifr_n[FLAG_T2] = 1'b0;
							t2_armed_n     = 1'b1;
						end else begin
							rd = t2_count_q[15:8];
						end
					end
					REG_SR: begin
						ifr_n[FLAG_SR] = 1'b0;
						if (wr) begin
							sr_n = d;
							// writing zero in phi2 shift-out mode pulls CB2 low
							if (sr_mode == SR_MODE_OUT_PHI2 && d == 8'h00)
								cb2_n = 1'b0;
						end else begin
							rd = sr_q;
						end
					end
					REG_ACR: begin
						if (wr) begin
							if (acr_q[4] && !d[4])
								cb2_n = 1'b1;
							acr_n = d;
							if (d[4:2] == SR_MODE_OFF)
								ifr_n[FLAG_SR] = 1'b0;
						end else begin
							rd = acr_q;
						end
					end
					REG_PCR: begin
						if (wr) pcr_n = d;
						else rd = pcr_q;
					end
					REG_IFR: begin
						if (wr) ifr_n = ifr_q & ~d[NUM_FLAGS-1:0];
						else rd = {|(ifr_q & ier_q), ifr_q};
					end
					REG_IER: begin
						if (wr) begin
							if (d[7]) ier_n = ier_q | d[NUM_FLAGS-1:0];
							else ier_n = ier_q & ~d[NUM_FLAGS-1:0];
						end else begin
							rd = {1'b1, ier_q};
						end
					end
					default: ;
				endcase
			end
			CMD_TICK: begin
				if (t1_count_q == 16'd1) begin
					if (acr_q[6]) begin
						// free-running: reload and flag every expiry
						t1_count_n     = t1_latch_q;
						ifr_n[FLAG_T1] = 1'b1;
						if (acr_q[7])
							pb7_tog_n = ~pb7_tog_q;
					end else begin
						t1_count_n = 16'd0;
						if (t1_armed_q) begin
							t1_armed_n     = 1'b0;
							ifr_n[FLAG_T1] = 1'b1;
						end
					end
				end else begin
					t1_count_n = t1_count_q - 16'd1;
				end
				if (t2_count_q == 16'd1 && t2_armed_q) begin
					t2_armed_n     = 1'b0;
					ifr_n[FLAG_T2] = 1'b1;
				end
				t2_count_n = t2_count_q - 16'd1;
			end
			CMD_SHIFT_IN: begin
				if (sr_mode == SR_MODE_IN_EXT) begin
					sr_n            = item.shift_byte;
					ifr_n[FLAG_SR]  = 1'b1;
					ifr_n[FLAG_CB1] = 1'b1;
					ok              = 1'b1;
				end
			end
			CMD_SHIFT_OUT: begin
				if (sr_mode == SR_MODE_OUT_EXT) begin
					ifr_n[FLAG_SR]  = 1'b1;
					ifr_n[FLAG_CB1] = 1'b1;
					cb2_n           = sr_q[0];
					rd              = sr_q;
					ok              = 1'b1;
				end
			end
			CMD_CA1: ifr_n[FLAG_CA1] = 1'b1;
			CMD_CA2: ifr_n[FLAG_CA2] = 1'b1;
			CMD_CB1: ifr_n[FLAG_CB1] = 1'b1;
			CMD_CB2: ifr_n[FLAG_CB2] = 1'b1;
			default: ;
		endcase
	end

	// pin levels as seen after this beat's update
	assign drv_a = (ora_n & ddra_n) | (~ddra_n & cfg.port_a_float_value);
	assign drv_b = ((orb_n & ddrb_n) | (~ddrb_n & cfg.port_b_float_value))
		^ {pb7_tog_n, 7'b0};

	always_comb begin
		result.read_data  = rd;
		result.port_a_out = drv_a;
		result.port_b_out = drv_b;
		result.cb2_level  = cb2_n;
		result.irq        = |(ifr_n & ier_n);
		result.shift_ok   = ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ora_q          <= '0;
			orb_q          <= '0;
			ddra_q         <= '0;
			ddrb_q         <= '0;
			t1_latch_q     <= '0;
			t1_count_q     <= '0;
			t2_count_q     <= '0;
			t2_latch_low_q <= '0;
			sr_q           <= '0;
			acr_q          <= '0;
			pcr_q          <= '0;
			ifr_q          <= '0;
			ier_q          <= '0;
			t1_armed_q     <= 1'b0;
			t2_armed_q     <= 1'b0;
			pb7_tog_q      <= 1'b0;
			cb2_q          <= 1'b1;
		end else if (en) begin
			ora_q          <= ora_n;
			orb_q          <= orb_n;
			ddra_q         <= ddra_n;
			ddrb_q         <= ddrb_n;
			t1_latch_q     <= t1_latch_n;
			t1_count_q     <= t1_count_n;
			t2_count_q     <= t2_count_n;
			t2_latch_low_q <= t2_latch_low_n;
			sr_q           <= sr_n;
			acr_q          <= acr_n;
			pcr_q          <= pcr_n;
			ifr_q          <= ifr_n;
			ier_q          <= ier_n;
			t1_armed_q     <= t1_armed_n;
			t2_armed_q     <= t2_armed_n;
			pb7_tog_q      <= pb7_tog_n;
			cb2_q          <= cb2_n;
		end
	end

endmodule
`default_nettype wire

>>> design/versatile_interface_adapter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An item beat reaches the result beat through the input register, then the result register.
// Throughput: one item per cycle unless a held result stalls; core state updates on advance.
// The result register lets a new item enter while the previous result waits.
// Reset (arst_n low, async): all adapter state clears, CB2 level goes high,
// config registers return to 0xFF; no clearing pass is needed.
// ----------------------------------------------------------------------------
// versatile_interface_adapter_unit
// Top level: input register, config registers, adapter core, result register.
// ----------------------------------------------------------------------------
module versatile_interface_adapter_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  via_pkg::in_item_t   item,
	output logic                result_valid,
	input  wire                 result_ready,
	output via_pkg::out_item_t  result,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [7:0]          cfg_index,
	input  wire  [7:0]          cfg_data
);
	import via_pkg::*;

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;
	out_item_t core_res;
	logic      adv;

	assign cfg_ready = 1'b1;

	// s1 moves into the result register when that slot is free or draining
	assign adv        = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PA_MASK:  cfg_q.port_a_input_mask  <= cfg_data;
				CFG_PB_MASK:  cfg_q.port_b_input_mask  <= cfg_data;
				CFG_PA_FLOAT: cfg_q.port_a_float_value <= cfg_data;
				CFG_PB_FLOAT: cfg_q.port_b_float_value <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready)
				valid_s1 <= item_valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (result_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
		if (adv)
			res_s2 <= core_res;
	end

	via_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (core_res)
	);

	assign result_valid = valid_s2;
	assign result       = res_s2;

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("input stage empty but item_ready low");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> valid_s1)
		else $error("accepted beat did not reach input stage");

	a_adv_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result_valid)
		else $error("core result lost on its way to the result register");

	a_no_adv_unless_s1: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> valid_s1 && (!valid_s2 || result_ready))
		else $error("core advanced without a held item or result space");
`endif

endmodule
`default_nettype wire
